@@ hdl/psw_pkg.sv @@
package psw_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_NEW   = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [1:0] REG_BAND_ROWS   = 2'd1;
  localparam logic [1:0] REG_FINAL_BLOCK = 2'd2;
  localparam int unsigned CFG_ADDR_W     = 4;

  localparam logic [7:0]  ROW_BYTES_RST   = 8'd40;
  localparam logic [7:0]  BAND_ROWS_RST   = 8'd16;
  localparam logic        FINAL_BLOCK_RST = 1'b1;

  localparam logic [16:0] ADLER_MOD       = 17'd65521;
  localparam logic [31:0] STORED_OVERHEAD = 32'd5;
  localparam logic [31:0] CHECK_LEN       = 32'd4;
  localparam logic [7:0]  FILTER_NONE     = 8'h00;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

  // Last sequencer step of each multi-byte job.
  localparam logic [3:0] OPEN_LAST_STEP  = 4'd12;
  localparam logic [3:0] CHECK_LAST_STEP = 4'd11;
  localparam logic [3:0] CRC_LAST_STEP   = 4'd3;
  localparam logic [3:0] PIX_LAST_STEP   = 4'd1;
  localparam logic [3:0] PIX_TAIL_STEP   = 4'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  typedef enum logic [2:0] {
    JOB_NEW,
    JOB_OPEN,
    JOB_PIX,
    JOB_ERR,
    JOB_CHECK,
    JOB_CRC
  } job_kind_t;

  // Work handed from the classifier to the byte sequencer.
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  pixel;
    logic        filter;     // row starts: emit the filter byte first
    logic        tail;       // band ends: emit the chunk CRC after the pixel
    logic [15:0] len;        // stored block LEN
    logic        final_blk;
  } job_t;

  function automatic logic [7:0] eff8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
    end
    return x;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] type_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h49;
      2'd1:    r = 8'h44;
      2'd2:    r = 8'h41;
      default: r = 8'h54;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/psw_front.sv @@
module psw_front import psw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  input  logic [7:0] row_bytes,
  input  logic [7:0] band_rows,
  input  logic     final_block,
  output job_t     job
);

  logic [7:0] byte_in_row_r, byte_in_row_nxt;
  logic [7:0] row_in_band_r, row_in_band_nxt;
  logic       band_open_r, band_open_nxt;
  logic       pending_r, pending_nxt;

  logic [8:0]  byte_inc;
  logic [8:0]  row_inc;
  logic [16:0] len_prod;
  logic [7:0]  rb_eff;
  logic [7:0]  br_eff;

  assign rb_eff   = eff8(row_bytes);
  assign br_eff   = eff8(band_rows);
  assign byte_inc = {1'b0, byte_in_row_r} + 9'd1;
  assign row_inc  = {1'b0, row_in_band_r} + 9'd1;
  assign len_prod = br_eff * ({1'b0, rb_eff} + 9'd1);

  always_comb begin
    job             = '0;
    job.kind        = JOB_NEW;
    job.pixel       = item.pixel_byte;
    job.len         = len_prod[15:0];
    job.final_blk   = final_block;
    byte_in_row_nxt = byte_in_row_r;
    row_in_band_nxt = row_in_band_r;
    band_open_nxt   = band_open_r;
    pending_nxt     = 1'b0;
    if (cmd_t'(item.cmd) == CMD_CLOSE && pending_r) begin
      job.kind = JOB_CRC;
    end else begin
      case (cmd_t'(item.cmd))
        CMD_NEW: begin
          job.kind        = JOB_NEW;
          byte_in_row_nxt = 8'd0;
          row_in_band_nxt = 8'd0;
          band_open_nxt   = 1'b0;
        end
        CMD_OPEN: begin
          job.kind        = JOB_OPEN;
          byte_in_row_nxt = 8'd0;
          row_in_band_nxt = 8'd0;
          band_open_nxt   = 1'b1;
        end
        CMD_PIXEL: begin
          if (!band_open_r) begin
            job.kind = JOB_ERR;
          end else begin
            job.kind   = JOB_PIX;
            job.filter = (byte_in_row_r == 8'd0);
            if (byte_inc >= {1'b0, rb_eff}) begin
              byte_in_row_nxt = 8'd0;
              if (row_inc >= {1'b0, br_eff}) begin
                job.tail        = 1'b1;
                row_in_band_nxt = 8'd0;
                band_open_nxt   = 1'b0;
              end else begin
                row_in_band_nxt = row_inc[7:0];
              end
            end else begin
              byte_in_row_nxt = byte_inc[7:0];
            end
          end
        end
        default: begin
          job.kind        = JOB_CHECK;
          byte_in_row_nxt = 8'd0;
          row_in_band_nxt = 8'd0;
          band_open_nxt   = 1'b0;
          pending_nxt     = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r <= 8'd0;
      row_in_band_r <= 8'd0;
      band_open_r   <= 1'b0;
      pending_r     <= 1'b0;
    end else if (accept) begin
      byte_in_row_r <= byte_in_row_nxt;
      row_in_band_r <= row_in_band_nxt;
      band_open_r   <= band_open_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

@@ hdl/psw_queue.sv @@
module psw_queue import psw_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign valid   = (count_r != '0);
  assign pop_job = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("job queue count beyond depth");

endmodule

@@ hdl/psw_back.sv @@
module psw_back import psw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job_in,
  output logic      job_pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_pop
);

  job_t       job_r;
  logic [3:0] step_r;
  logic       busy_r;
  logic [15:0] adler_low_r, adler_low_nxt;
  logic [15:0] adler_high_r, adler_high_nxt;
  logic [31:0] crc_r, crc_nxt;
  out_item_t   out_item_r;
  logic        out_valid_r;

  logic        advance;
  logic        emit;
  logic        is_last;
  logic        produces;
  logic        crc_cov;
  logic        data_cov;
  logic        crc_clear;
  logic        adler_clear;
  logic [7:0]  byte_val;
  logic        err_flag;
  logic [31:0] crc_inv;
  logic [31:0] chunk_len;
  logic [1:0]  tail_idx;
  logic [16:0] low_sum;
  logic [16:0] low_mod;
  logic [16:0] high_sum;
  logic [3:0]  start_step;

  assign crc_inv   = ~crc_r;
  assign chunk_len = {16'd0, job_r.len} + STORED_OVERHEAD;
  assign tail_idx  = 2'(step_r - 4'd2);

  // Byte selection for the current step of the job in hand.
  always_comb begin
    byte_val    = 8'd0;
    err_flag    = 1'b0;
    is_last     = 1'b1;
    produces    = 1'b1;
    crc_cov     = 1'b0;
    data_cov    = 1'b0;
    crc_clear   = 1'b0;
    adler_clear = 1'b0;
    case (job_r.kind)
      JOB_NEW: begin
        produces    = 1'b0;
        crc_clear   = 1'b1;
        adler_clear = 1'b1;
      end
      JOB_OPEN: begin
        is_last   = (step_r == OPEN_LAST_STEP);
        crc_cov   = (step_r >= 4'd4);
        crc_clear = (step_r == 4'd0);
        case (step_r) inside
          [4'd0:4'd3]: byte_val = be_byte(chunk_len, step_r[1:0]);
          [4'd4:4'd7]: byte_val = type_byte(step_r[1:0]);
          4'd8:        byte_val = {7'd0, job_r.final_blk};
          4'd9:        byte_val = job_r.len[7:0];
          4'd10:       byte_val = job_r.len[15:8];
          4'd11:       byte_val = ~job_r.len[7:0];
          default:     byte_val = ~job_r.len[15:8];
        endcase
      end
      JOB_PIX: begin
        is_last = job_r.tail ? (step_r == PIX_TAIL_STEP) : (step_r == PIX_LAST_STEP);
        case (step_r) inside
          4'd0: begin
            byte_val = FILTER_NONE;
            data_cov = 1'b1;
          end
          4'd1: begin
            byte_val = job_r.pixel;
            data_cov = 1'b1;
          end
          default: begin
            byte_val  = be_byte(crc_inv, tail_idx);
            crc_clear = (step_r == PIX_TAIL_STEP);
          end
        endcase
      end
      JOB_ERR: begin
        err_flag = 1'b1;
      end
      JOB_CHECK: begin
        is_last   = (step_r == CHECK_LAST_STEP);
        crc_cov   = (step_r >= 4'd4);
        crc_clear = (step_r == 4'd0);
        case (step_r) inside
          [4'd0:4'd3]: byte_val = be_byte(CHECK_LEN, step_r[1:0]);
          [4'd4:4'd7]: byte_val = type_byte(step_r[1:0]);
          default:     byte_val = be_byte({adler_high_r, adler_low_r}, step_r[1:0]);
        endcase
      end
      default: begin
        is_last   = (step_r == CRC_LAST_STEP);
        crc_clear = (step_r == CRC_LAST_STEP);
        byte_val  = be_byte(crc_inv, step_r[1:0]);
      end
    endcase
  end

  assign advance = busy_r && (!produces || !out_valid_r || out_pop);
  assign emit    = advance && produces;
  assign job_pop = job_valid && (!busy_r || (advance && is_last));

  assign start_step = (job_in.kind == JOB_PIX && !job_in.filter) ? 4'd1 : 4'd0;

  // Adler-32 sums stay below twice the modulus, so one subtract reduces each.
  assign low_sum  = {1'b0, adler_low_r} + {9'd0, byte_val};
  assign low_mod  = (low_sum >= ADLER_MOD) ? low_sum - ADLER_MOD : low_sum;
  assign high_sum = {1'b0, adler_high_r} + low_mod;

  always_comb begin
    adler_low_nxt  = adler_low_r;
    adler_high_nxt = adler_high_r;
    crc_nxt        = crc_r;
    if (advance) begin
      if (adler_clear) begin
        adler_low_nxt  = 16'd1;
        adler_high_nxt = 16'd0;
      end else if (data_cov) begin
        adler_low_nxt  = low_mod[15:0];
        adler_high_nxt = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD)
                                                 : high_sum[15:0];
      end
      if (crc_clear) begin
        crc_nxt = 32'hFFFFFFFF;
      end else if (crc_cov || data_cov) begin
        crc_nxt = crc_byte(crc_r, byte_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      step_r       <= 4'd0;
      adler_low_r  <= 16'd1;
      adler_high_r <= 16'd0;
      crc_r        <= 32'hFFFFFFFF;
      out_valid_r  <= 1'b0;
    end else begin
      adler_low_r  <= adler_low_nxt;
      adler_high_r <= adler_high_nxt;
      crc_r        <= crc_nxt;
      if (job_pop) begin
        busy_r <= 1'b1;
        step_r <= start_step;
      end else if (advance && is_last) begin
        busy_r <= 1'b0;
      end else if (advance) begin
        step_r <= step_r + 4'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_in;
    end
    if (emit) begin
      out_item_r.out_byte <= byte_val;
      out_item_r.last     <= is_last;
      out_item_r.error    <= err_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_pop))
    else $error("output register overwritten before its transfer");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= OPEN_LAST_STEP))
    else $error("sequencer step out of range");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && err_flag) |-> is_last)
    else $error("error result is not a single transfer");

  a_adler_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, adler_low_r} < ADLER_MOD) && ({1'b0, adler_high_r} < ADLER_MOD))
    else $error("Adler-32 sum not reduced");

endmodule

@@ hdl/png_stored_idat_stream_writer.sv @@
// Channel   Ports                              Transfer when
// input     in_item, push, full                push && !full
// result    out_item, empty, pop               pop && !empty
// config    psel penable pwrite paddr pwdata   psel && penable && pwrite && pready
//           prdata pready
//
// The byte sequencer writes one result per cycle while the output register is free or popped.
// Bytes per item: a pixel byte yields 1, 2 at a row start and 4 more at a band end;
// open band yields 13, close 12 and a close right after it 4, an error result 1, a new image none.
// Reset is synchronous and active low; there is no clearing pass after it.
// The classifier takes an item every cycle until the job queue of QUEUE_DEPTH entries fills.
// A result waiting in the output register stalls only the sequencer, not the input side.
module png_stored_idat_stream_writer import psw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  push,
  output logic                  full,
  output out_item_t             out_item,
  output logic                  empty,
  input  logic                  pop,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] row_bytes_r;
  logic [7:0] band_rows_r;
  logic       final_block_r;
  logic       cfg_write;
  logic [1:0] reg_idx;

  logic       in_accept;
  job_t       front_job;
  job_t       queue_job;
  logic       queue_valid;
  logic       queue_pop;
  logic       out_valid;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= ROW_BYTES_RST;
      band_rows_r   <= BAND_ROWS_RST;
      final_block_r <= FINAL_BLOCK_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ROW_BYTES:   row_bytes_r   <= pwdata[7:0];
        REG_BAND_ROWS:   band_rows_r   <= pwdata[7:0];
        REG_FINAL_BLOCK: final_block_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_BYTES:   prdata = {24'd0, row_bytes_r};
      REG_BAND_ROWS:   prdata = {24'd0, band_rows_r};
      REG_FINAL_BLOCK: prdata = {31'd0, final_block_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign in_accept = push && !full;

  psw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .item        (in_item),
    .row_bytes   (row_bytes_r),
    .band_rows   (band_rows_r),
    .final_block (final_block_r),
    .job         (front_job)
  );

  psw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_job (front_job),
    .full     (full),
    .pop      (queue_pop),
    .valid    (queue_valid),
    .pop_job  (queue_job)
  );

  psw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (queue_valid),
    .job_in    (queue_job),
    .job_pop   (queue_pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_pop   (pop)
  );

  assign empty = !out_valid;

endmodule
